[src/lpps_pkg.sv]
// Shared constants, types and helpers of the line position PID steering block.
package lpps_pkg;

  // Sensor array
  localparam int NUM_SENSORS = 4;
  localparam int SENSOR_W    = 4;
  localparam int WEIGHT_W    = 12;
  localparam int SUM_W       = WEIGHT_W + $clog2(NUM_SENSORS);
  localparam int CNT_W       = $clog2(NUM_SENSORS + 1);

  // Error path and controller state
  localparam int ERR_W   = 16;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int INTEG_W = 24;
  localparam int ACC_W   = INTEG_W + 1;
  localparam int ILIM_W  = 23;
  localparam int LOST_W  = 15;

  // Gains and serial multiplier
  localparam int GAIN_W = 16;
  localparam int BIT_W  = $clog2(GAIN_W);
  localparam int PID_W  = 42;

  // Speed limits
  localparam int BASE_W = 15;
  localparam int FRAC_W = 10;
  localparam int PROD_W = BASE_W + FRAC_W;
  localparam int CLP_W  = PROD_W + 8 + 1;
  localparam int WHL_W  = CLP_W + 1;
  localparam int TGT_W  = 16;
  localparam int TQ_W   = CLP_W - 16;
  localparam int TGT_MAX = 2 ** (TGT_W - 1) - 1;
  localparam int TGT_MIN = -(2 ** (TGT_W - 1));

  // Division by three as multiply by reciprocal, exact for sums below 2**17
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int          RECIP3_SHIFT = 17;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE,
    REG_BASE_SPEED,
    REG_SENSOR_WEIGHTS,
    REG_PID_GAINS,
    REG_INTEGRAL_LIMIT,
    REG_LOST_ERROR,
    REG_PID_LIMIT_FRAC,
    REG_SPEED_LIMIT_FRAC
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_INTEG,
    ST_MUL,
    ST_CLAMP,
    ST_WHEEL,
    ST_DONE
  } state_t;

  // Q.16 wheel value to integer target: truncate toward zero, then saturate
  function automatic logic signed [TGT_W-1:0] to_target(logic signed [CLP_W-1:0] v);
    logic signed [CLP_W-1:0] adj;
    logic signed [TQ_W-1:0]  q;
    adj = v[CLP_W-1] ? v + CLP_W'(65535) : v;
    q   = adj[CLP_W-1:16];
    if (q > TQ_W'(TGT_MAX)) begin
      to_target = TGT_W'(TGT_MAX);
    end else if (q < TQ_W'(TGT_MIN)) begin
      to_target = TGT_W'(TGT_MIN);
    end else begin
      to_target = q[TGT_W-1:0];
    end
  endfunction

endpackage

[src/line_position_pid_steering.sv]
// Line position PID steering: sensor words in, differential wheel targets out.
//
// Input channel: in_valid / in_stall carry one sensor_bits word per control tick.
// Output channel: out_valid / out_stall carry left_target, right_target,
// line_error, active_mask and drive_on, one word per input word.
// Configuration: APB-style write/read port, registers at byte address 8*i.
// Write registers only while no word is in flight.
//
// Timing: with tracking on, a word passes the sum, divide, integrate,
// multiply, clamp and wheel steps; the next word is taken once idle. The
// multiply step is bit-serial and steps through the 16 gain bits one per
// cycle (kp, ki, kd and both limit products in parallel).
// With tracking off the sequencer goes from accept straight to its final step.
// The output register holds a finished word while the next word is accepted
// and worked on; a stalled receiver only holds the block at its final step.
// Reset clears the configuration registers, the sequencer, out_valid, the
// integral and the last error; any write to the enable register clears the
// integral and the last error as well.
module line_position_pid_steering (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [lpps_pkg::SENSOR_W-1:0]          sensor_bits,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lpps_pkg::TGT_W-1:0]      left_target,
  output logic signed [lpps_pkg::TGT_W-1:0]      right_target,
  output logic signed [lpps_pkg::ERR_W-1:0]      line_error,
  output logic [lpps_pkg::SENSOR_W-1:0]          active_mask,
  output logic                                   drive_on,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lpps_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [lpps_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [lpps_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import lpps_pkg::*;

  localparam logic [SENSOR_W-1:0] SENSOR_MASK = SENSOR_W'((1 << NUM_SENSORS) - 1);

  // configuration registers
  logic                            enable;
  logic [BASE_W-1:0]               base_speed;
  logic [NUM_SENSORS*WEIGHT_W-1:0] sensor_weights;
  logic [3*GAIN_W-1:0]             pid_gains;
  logic [ILIM_W-1:0]               integral_limit;
  logic [LOST_W-1:0]               lost_error;
  logic [FRAC_W-1:0]               pid_limit_frac;
  logic [FRAC_W-1:0]               speed_limit_frac;

  // controller state
  logic signed [ERR_W-1:0]   last_error;
  logic signed [INTEG_W-1:0] integral;

  // sequencer
  state_t state, state_next;
  logic   in_acc, load_out, cfg_wr;
  reg_idx_t cfg_idx;

  // working registers
  logic                      run_on;
  logic [SENSOR_W-1:0]       mask;
  logic [SUM_W-1:0]          sum_mag;
  logic                      sum_neg;
  logic [CNT_W-1:0]          count;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic [GAIN_W-1:0]         kp_sh, ki_sh, kd_sh, pf_sh, sf_sh;
  logic [BIT_W-1:0]          bitcnt;
  logic signed [PID_W-1:0]   pacc;
  logic [PROD_W-1:0]         plim_acc, vlim_acc;
  logic signed [CLP_W-1:0]   pid_c, lq, rq;

  // next values
  logic signed [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]          count_next;
  logic [SUM_W-1:0]          sum_mag_next;
  logic [SUM_W+15:0]         prod3;
  logic [SUM_W-1:0]          quot;
  logic signed [ERR_W-1:0]   quot_s, lost_s, err_next;
  logic signed [ACC_W-1:0]   acc, lim_s;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [PID_W-1:0]   tp, ti, td, pacc_next, plim_w;
  logic signed [CLP_W-1:0]   plim_s, pid_next, lq_next, rq_next;
  logic signed [WHL_W-1:0]   base16, vlim_w, lw, rw;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      base_speed       <= '0;
      sensor_weights   <= '0;
      pid_gains        <= '0;
      integral_limit   <= '0;
      lost_error       <= '0;
      pid_limit_frac   <= '0;
      speed_limit_frac <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:           enable           <= pwdata[0];
        REG_BASE_SPEED:       base_speed       <= pwdata[BASE_W-1:0];
        REG_SENSOR_WEIGHTS:   sensor_weights   <= pwdata[NUM_SENSORS*WEIGHT_W-1:0];
        REG_PID_GAINS:        pid_gains        <= pwdata[3*GAIN_W-1:0];
        REG_INTEGRAL_LIMIT:   integral_limit   <= pwdata[ILIM_W-1:0];
        REG_LOST_ERROR:       lost_error       <= pwdata[LOST_W-1:0];
        REG_PID_LIMIT_FRAC:   pid_limit_frac   <= pwdata[FRAC_W-1:0];
        REG_SPEED_LIMIT_FRAC: speed_limit_frac <= pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_ENABLE:           prdata = CFG_DATA_W'(enable);
      REG_BASE_SPEED:       prdata = CFG_DATA_W'(base_speed);
      REG_SENSOR_WEIGHTS:   prdata = CFG_DATA_W'(sensor_weights);
      REG_PID_GAINS:        prdata = CFG_DATA_W'(pid_gains);
      REG_INTEGRAL_LIMIT:   prdata = CFG_DATA_W'(integral_limit);
      REG_LOST_ERROR:       prdata = CFG_DATA_W'(lost_error);
      REG_PID_LIMIT_FRAC:   prdata = CFG_DATA_W'(pid_limit_frac);
      REG_SPEED_LIMIT_FRAC: prdata = CFG_DATA_W'(speed_limit_frac);
      default:              prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc) state_next = enable ? ST_SUM : ST_DONE;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_INTEG;
      ST_INTEG: state_next = ST_MUL;
      ST_MUL:   if (bitcnt == '0) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_WHEEL;
      ST_WHEEL: state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    in_acc   = in_valid && (state == ST_IDLE);
    load_out = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sum and count of active sensor weights
  always_comb begin
    sum_next   = '0;
    count_next = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (mask[i]) begin
        sum_next   = sum_next + SUM_W'(signed'(sensor_weights[i*WEIGHT_W +: WEIGHT_W]));
        count_next = count_next + CNT_W'(1);
      end
    end
    sum_mag_next = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
  end

  // mean by count, or the lost-line error
  always_comb begin
    prod3  = sum_mag * RECIP3;
    case (count)
      CNT_W'(1): quot = sum_mag;
      CNT_W'(2): quot = sum_mag >> 1;
      CNT_W'(3): quot = SUM_W'(prod3 >> RECIP3_SHIFT);
      CNT_W'(4): quot = sum_mag >> 2;
      default:   quot = '0;
    endcase
    quot_s = signed'(ERR_W'(quot));
    lost_s = signed'(ERR_W'(lost_error));
    if (count == '0) begin
      if (last_error[ERR_W-1]) begin
        err_next = -lost_s;
      end else if (last_error != '0) begin
        err_next = lost_s;
      end else begin
        err_next = '0;
      end
    end else begin
      err_next = sum_neg ? -quot_s : quot_s;
    end
  end

  // integral update with symmetric clamp
  always_comb begin
    acc   = ACC_W'(integral) + ACC_W'(err);
    lim_s = signed'(ACC_W'(integral_limit));
    if (acc > lim_s) begin
      integ_next = INTEG_W'(lim_s);
    end else if (acc < -lim_s) begin
      integ_next = INTEG_W'(-lim_s);
    end else begin
      integ_next = INTEG_W'(acc);
    end
  end

  // one gain bit per cycle, MSB first
  always_comb begin
    tp        = kp_sh[GAIN_W-1] ? PID_W'(err) : '0;
    ti        = ki_sh[GAIN_W-1] ? PID_W'(integral) : '0;
    td        = kd_sh[GAIN_W-1] ? PID_W'(diff) : '0;
    pacc_next = (pacc <<< 1) + tp + ti + td;
  end

  // PID output clamp
  always_comb begin
    plim_s = signed'({1'b0, plim_acc, 8'b0});
    plim_w = PID_W'(plim_s);
    if (pacc > plim_w) begin
      pid_next = plim_s;
    end else if (pacc < -plim_w) begin
      pid_next = -plim_s;
    end else begin
      pid_next = CLP_W'(pacc);
    end
  end

  // wheel values with magnitude clamp
  always_comb begin
    base16 = signed'(WHL_W'({base_speed, 16'b0}));
    vlim_w = signed'(WHL_W'({vlim_acc, 8'b0}));
    lw     = base16 + WHL_W'(pid_c);
    rw     = base16 - WHL_W'(pid_c);
    if (lw > vlim_w) begin
      lq_next = CLP_W'(vlim_w);
    end else if (lw < -vlim_w) begin
      lq_next = CLP_W'(-vlim_w);
    end else begin
      lq_next = CLP_W'(lw);
    end
    if (rw > vlim_w) begin
      rq_next = CLP_W'(vlim_w);
    end else if (rw < -vlim_w) begin
      rq_next = CLP_W'(-vlim_w);
    end else begin
      rq_next = CLP_W'(rw);
    end
  end

  // controller state: cleared by reset and by an enable write
  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
    end else if (cfg_wr && cfg_idx == REG_ENABLE) begin
      integral   <= '0;
      last_error <= '0;
    end else if (state == ST_INTEG) begin
      integral   <= integ_next;
      last_error <= err;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        run_on <= enable;
        mask   <= sensor_bits & SENSOR_MASK;
      end
      ST_SUM: begin
        sum_mag <= sum_mag_next;
        sum_neg <= sum_next[SUM_W-1];
        count   <= count_next;
      end
      ST_DIV: begin
        err <= err_next;
      end
      ST_INTEG: begin
        diff     <= DIFF_W'(err) - DIFF_W'(last_error);
        kp_sh    <= pid_gains[0*GAIN_W +: GAIN_W];
        ki_sh    <= pid_gains[1*GAIN_W +: GAIN_W];
        kd_sh    <= pid_gains[2*GAIN_W +: GAIN_W];
        pf_sh    <= GAIN_W'(pid_limit_frac);
        sf_sh    <= GAIN_W'(speed_limit_frac);
        bitcnt   <= BIT_W'(GAIN_W - 1);
        pacc     <= '0;
        plim_acc <= '0;
        vlim_acc <= '0;
      end
      ST_MUL: begin
        pacc     <= pacc_next;
        plim_acc <= (plim_acc << 1) + (pf_sh[GAIN_W-1] ? PROD_W'(base_speed) : '0);
        vlim_acc <= (vlim_acc << 1) + (sf_sh[GAIN_W-1] ? PROD_W'(base_speed) : '0);
        kp_sh    <= {kp_sh[GAIN_W-2:0], 1'b0};
        ki_sh    <= {ki_sh[GAIN_W-2:0], 1'b0};
        kd_sh    <= {kd_sh[GAIN_W-2:0], 1'b0};
        pf_sh    <= {pf_sh[GAIN_W-2:0], 1'b0};
        sf_sh    <= {sf_sh[GAIN_W-2:0], 1'b0};
        bitcnt   <= bitcnt - BIT_W'(1);
      end
      ST_CLAMP: begin
        pid_c <= pid_next;
      end
      ST_WHEEL: begin
        lq <= lq_next;
        rq <= rq_next;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_target  <= run_on ? to_target(lq) : '0;
      right_target <= run_on ? to_target(rq) : '0;
      line_error   <= run_on ? err : '0;
      active_mask  <= run_on ? mask : '0;
      drive_on     <= run_on;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is still in flight");

  a_off_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_on |->
      left_target == '0 && right_target == '0 && line_error == '0 && active_mask == '0)
    else $error("nonzero result while tracking is off");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_on && active_mask != '0 |->
      line_error >= -16'sd2048 && line_error <= 16'sd2047)
    else $error("mean position error outside weight range");

  a_pid_clamped: assert property (@(posedge clk) disable iff (rst)
    state == ST_WHEEL |-> pid_c <= plim_s && pid_c >= -plim_s)
    else $error("PID output beyond its limit");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    load_out |=> state == ST_IDLE && out_valid)
    else $error("result load did not release the sequencer");

endmodule
